[hdl/i2s_pkg.sv]
// ----------------------------------------------------------------------------
// i2s_pkg
// Shared types, byte codes and the JIS to Shift_JIS pair conversion.
// ----------------------------------------------------------------------------
package i2s_pkg;

	// Escape sequence bytes
	localparam logic [7:0] ESC_CODE    = 8'h1B;
	localparam logic [7:0] DOLLAR_CODE = 8'h24;
	localparam logic [7:0] LPAREN_CODE = 8'h28;
	localparam logic [7:0] B_CODE      = 8'h42;
	localparam logic [7:0] J_CODE      = 8'h4A;

	// Pair conversion offsets
	localparam logic [8:0] LEAD_ODD_OFS   = 9'h071;
	localparam logic [8:0] LEAD_EVEN_OFS  = 9'h070;
	localparam logic [8:0] LEAD_HIGH_LIM  = 9'h09F;
	localparam logic [8:0] LEAD_HIGH_ADJ  = 9'h040;
	localparam logic [8:0] TRAIL_ODD_OFS  = 9'h01F;
	localparam logic [8:0] TRAIL_EVEN_OFS = 9'h07E;
	localparam logic [8:0] TRAIL_GAP      = 9'h07F;

	// Most result bytes one request can cause
	localparam int RUN_MAX = 3;

	// Results of one request, held as one queue entry
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [1:0]              cnt;
		logic                    eot;
	} run_t;

	// JIS pair to Shift_JIS pair: {lead, trail}, wrapping modulo 256
	function automatic logic [15:0] jis_to_sjis(input logic [7:0] c1, input logic [7:0] c2);
		logic [8:0] lead;
		logic [8:0] trail;
		if (c1[0]) begin
			lead  = {2'b00, c1[7:1]} + LEAD_ODD_OFS;
			trail = {1'b0, c2} + TRAIL_ODD_OFS;
			if (trail >= TRAIL_GAP) begin
				trail = trail + 9'd1;
			end
		end else begin
			lead  = {2'b00, c1[7:1]} + LEAD_EVEN_OFS;
			trail = {1'b0, c2} + TRAIL_EVEN_OFS;
		end
		if (lead > LEAD_HIGH_LIM) begin
			lead = lead + LEAD_HIGH_ADJ;
		end
		return {lead[7:0], trail[7:0]};
	endfunction

endpackage

[hdl/i2s_front.sv]
// ----------------------------------------------------------------------------
// i2s_front
// Escape tracking and pairing: turns one request into a run of result bytes.
// ----------------------------------------------------------------------------
module i2s_front import i2s_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output run_t       run,
	output logic       push
);

	logic       kanji_q;
	logic [7:0] pend0_q;
	logic [7:0] pend1_q;
	logic [1:0] pcnt_q;

	logic       kanji_d;
	logic [7:0] pend0_d;
	logic [7:0] pend1_d;
	logic [1:0] pcnt_d;
	logic [RUN_MAX-1:0][7:0] nb;
	logic [1:0] n;
	logic [15:0] pr;

	// Next state and result bytes for the current request
	always_comb begin
		nb      = '0;
		n       = 2'd0;
		kanji_d = kanji_q;
		pcnt_d  = pcnt_q;
		pend0_d = pend0_q;
		pend1_d = pend1_q;
		pr      = '0;

		if (pcnt_q == 2'd2) begin
			pcnt_d = 2'd0;
			if (pend0_q == ESC_CODE && pend1_q == DOLLAR_CODE && in_byte == B_CODE) begin
				kanji_d = 1'b1;
			end else if (pend0_q == ESC_CODE && pend1_q == LPAREN_CODE &&
				(in_byte == B_CODE || in_byte == J_CODE)) begin
				kanji_d = 1'b0;
			end else if (!kanji_q) begin
				nb[n] = pend0_q;
				n     = n + 2'd1;
				nb[n] = pend1_q;
				n     = n + 2'd1;
				if (in_byte == ESC_CODE) begin
					pend0_d = in_byte;
					pcnt_d  = 2'd1;
				end else begin
					nb[n] = in_byte;
					n     = n + 2'd1;
				end
			end else begin
				pr    = jis_to_sjis(pend0_q, pend1_q);
				nb[n] = pr[15:8];
				n     = n + 2'd1;
				nb[n] = pr[7:0];
				n     = n + 2'd1;
				pend0_d = in_byte;
				pcnt_d  = 2'd1;
			end
		end else if (pcnt_q == 2'd1) begin
			if (pend0_q == ESC_CODE && (in_byte == DOLLAR_CODE || in_byte == LPAREN_CODE)) begin
				pend1_d = in_byte;
				pcnt_d  = 2'd2;
			end else if (!kanji_q) begin
				pcnt_d = 2'd0;
				nb[n]  = pend0_q;
				n      = n + 2'd1;
				if (in_byte == ESC_CODE) begin
					pend0_d = in_byte;
					pcnt_d  = 2'd1;
				end else begin
					nb[n] = in_byte;
					n     = n + 2'd1;
				end
			end else begin
				pcnt_d = 2'd0;
				pr     = jis_to_sjis(pend0_q, in_byte);
				nb[n]  = pr[15:8];
				n      = n + 2'd1;
				nb[n]  = pr[7:0];
				n      = n + 2'd1;
			end
		end else begin
			if (kanji_q || in_byte == ESC_CODE) begin
				pend0_d = in_byte;
				pcnt_d  = 2'd1;
			end else begin
				nb[n] = in_byte;
				n     = n + 2'd1;
			end
		end

		// End of text: flush what is still held, dropping an odd kanji byte
		if (end_of_text) begin
			if (pcnt_d == 2'd2) begin
				if (kanji_d) begin
					pr    = jis_to_sjis(pend0_d, pend1_d);
					nb[n] = pr[15:8];
					n     = n + 2'd1;
					nb[n] = pr[7:0];
					n     = n + 2'd1;
				end else begin
					nb[n] = pend0_d;
					n     = n + 2'd1;
					nb[n] = pend1_d;
					n     = n + 2'd1;
				end
			end else if (pcnt_d == 2'd1 && !kanji_d) begin
				nb[n] = pend0_d;
				n     = n + 2'd1;
			end
			pcnt_d  = 2'd0;
			pend0_d = '0;
			pend1_d = '0;
		end
	end

	assign run.bytes = nb;
	assign run.cnt   = n;
	assign run.eot   = end_of_text;
	assign push      = take && (n != 2'd0);

	// Mode and held bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kanji_q <= 1'b0;
			pcnt_q  <= 2'd0;
			pend0_q <= '0;
			pend1_q <= '0;
		end else if (take) begin
			kanji_q <= kanji_d;
			pcnt_q  <= pcnt_d;
			pend0_q <= pend0_d;
			pend1_q <= pend1_d;
		end
	end

endmodule

[hdl/i2s_run_fifo.sv]
// ----------------------------------------------------------------------------
// i2s_run_fifo
// Small queue of runs between the front and the back.
// ----------------------------------------------------------------------------
module i2s_run_fifo import i2s_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  run_t wr_run,
	input  logic pop,
	output run_t head,
	output logic empty,
	output logic full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	run_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign head  = mem_q[rd_ptr_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == FULL_CNT);

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_run;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[hdl/i2s_back.sv]
// ----------------------------------------------------------------------------
// i2s_back
// Serializes queued runs into single result bytes behind an output register.
// ----------------------------------------------------------------------------
module i2s_back import i2s_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  run_t       head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       text_done
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       done_q;
	logic       load;
	logic       at_end;

	assign load   = !empty && (!valid_q || !out_stall);
	assign at_end = (idx_q == head.cnt - 2'd1);
	assign pop    = load && at_end;

	// Byte index within the head run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (load) begin
			idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.bytes[idx_q];
			last_q <= at_end;
			done_q <= head.eot;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign run_last  = last_q;
	assign text_done = done_q;

endmodule

[hdl/iso2022jp_to_sjis_converter.sv]
// ----------------------------------------------------------------------------
// iso2022jp_to_sjis_converter
// ISO-2022-JP byte stream in, Shift_JIS byte stream out.
// ----------------------------------------------------------------------------
// One input request carries one text byte and is taken while in_stall is low;
// it yields zero to three result bytes, with run_last on the last one and
// text_done on all of them when end_of_text was set. Requests are taken
// every cycle while the run queue (RUN_DEPTH entries) has room; the output
// side sends one byte per cycle while out_stall is low, so sustained rate is
// set by that single output register. A byte reaches the output through a
// run queue entry and then the output register, also when nothing is queued.
// Escapes and odd trailing kanji bytes produce no output.
module iso2022jp_to_sjis_converter import i2s_pkg::*; #(
	parameter int RUN_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       text_done
);

	run_t new_run;
	run_t head;
	logic push;
	logic pop;
	logic empty;
	logic full;

	assign in_stall = full;

	// Front: classify bytes, build runs
	i2s_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (in_valid && !full),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.run         (new_run),
		.push        (push)
	);

	// Run queue
	i2s_run_fifo #(
		.DEPTH (RUN_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_run (new_run),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	// Back: emit bytes one per cycle while out_stall is low
	i2s_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.text_done (text_done)
	);

endmodule

[hdl/i2s_checker.sv]
// ----------------------------------------------------------------------------
// i2s_checker
// Port-level checks on the output stream of the converter.
// ----------------------------------------------------------------------------
module i2s_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       text_done
);

	logic       mid_run_q;
	logic       mid_done_q;
	logic [1:0] run_len_q;
	logic       out_take;

	assign out_take = out_valid && !out_stall;

	// Track position inside the current output run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_run_q  <= 1'b0;
			mid_done_q <= 1'b0;
			run_len_q  <= 2'd0;
		end else if (out_take) begin
			mid_run_q  <= !run_last;
			mid_done_q <= text_done;
			run_len_q  <= run_last ? 2'd0 : run_len_q + 2'd1;
		end
	end

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) &&
		$stable(run_last) && $stable(text_done))
		else $error("stalled result changed");

	// All bytes of a run agree on text_done
	a_run_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mid_run_q |-> text_done == mid_done_q)
		else $error("text_done changed inside a run");

	// A run holds at most three bytes
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_len_q == 2'd2 |-> run_last)
		else $error("run longer than three bytes");

	// No result shows as reset is released
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result shown right after reset");

endmodule

bind iso2022jp_to_sjis_converter i2s_checker u_i2s_checker (.*);
